[hw/rtl/isg_pkg.sv]
// ============================================================================
// isg_pkg : shared types and constants of the successor task scheduler
// Sizes of the slot table and the three stacks, operation codes, the
// sequencer state type and the shift control word of a stack cell.
// ============================================================================
package isg_pkg;

    // Sizes
    localparam int NUM_CPUS    = 16;
    localparam int TASK_BITS   = 16;
    localparam int READY_DEPTH = 256;
    localparam int UNBLK_DEPTH = 256;
    localparam int IDLE_DEPTH  = 16;

    // Fixed port widths
    localparam int FUNC_W    = 3;
    localparam int TASK_ID_W = 16;
    localparam int CPU_ID_W  = 4;

    // Derived widths
    localparam int SLOT_IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int RDY_CNT_W  = $clog2(READY_DEPTH + 1);
    localparam int UNB_CNT_W  = $clog2(UNBLK_DEPTH + 1);
    localparam int IDL_CNT_W  = $clog2(IDLE_DEPTH + 1);

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_ADD_READY = 3'd0,
        FN_UNBLOCK   = 3'd1,
        FN_GET_READY = 3'd2,
        FN_GET_IDLE  = 3'd3,
        FN_DISABLE   = 3'd4
    } func_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Shift control shared by every cell of one stack
    typedef struct packed {
        logic push;
        logic pop;
    } stk_ctl_t;

    typedef logic [TASK_BITS-1:0] task_t;

endpackage

[hw/rtl/isg_stack_cell.sv]
// ============================================================================
// isg_stack_cell : one entry of a shifting LIFO stack
// On push the cell takes the word of its upper neighbor, on pop the word of
// its lower neighbor; otherwise it holds.
// ============================================================================
module isg_stack_cell
    import isg_pkg::*;
(
    input  logic     clk,
    input  stk_ctl_t ctl,
    input  task_t    up_data,
    input  task_t    down_data,
    output task_t    data
);

    task_t data_reg;
    task_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.push)
        begin
            data_next = up_data;
        end
        else if (ctl.pop)
        begin
            data_next = down_data;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[hw/rtl/immediate_successor_task_scheduler.sv]
// ============================================================================
// immediate_successor_task_scheduler : hardware task dispatcher
// One successor slot per CPU plus LIFO stacks of ready tasks, unblocked
// tasks and idle CPUs, each stack built as a chain of shifting cells.
// ============================================================================
//
// Usage: drive func and its operands with start high while busy is low; the
// word is taken at that edge. Every operation executes against the slot
// table and the stack tops in the execute cycle, and the result appears in
// the cycle after it, with done high for exactly one cycle. busy is
// high during the execute cycle only, so a new word may be started in the
// same cycle that done is shown; no new word is taken while busy is high.
// The result cannot be held off: sample it whenever done is high. Every
// stack keeps its top in its first cell, and a push or pop shifts the whole
// chain by one cell in the execute cycle. No clearing pass follows reset;
// the block is ready at once.
//
module immediate_successor_task_scheduler
    import isg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // command side
    input  logic                 start,
    output logic                 busy,
    input  logic [FUNC_W-1:0]    func,
    input  logic [TASK_ID_W-1:0] task_id,
    input  logic [CPU_ID_W-1:0]  cpu_id,
    input  logic                 has_cpu,
    input  logic                 child_hint,
    input  logic                 force_req,
    // result side
    output logic                 done,
    output logic [TASK_ID_W-1:0] out_task,
    output logic                 task_valid,
    output logic [CPU_ID_W-1:0]  out_cpu,
    output logic                 cpu_valid,
    output logic                 overflow
);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg == ST_EXEC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Captured command word
    // ------------------------------------------------------------------
    logic [FUNC_W-1:0]   func_reg;
    task_t               task_reg;
    logic [CPU_ID_W-1:0] cpu_reg;
    logic                has_cpu_reg;
    logic                child_reg;
    logic                force_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= func;
            task_reg    <= TASK_BITS'(task_id);
            cpu_reg     <= cpu_id;
            has_cpu_reg <= has_cpu;
            child_reg   <= child_hint;
            force_reg   <= force_req;
        end
    end

    // ------------------------------------------------------------------
    // Successor slots: valid bits reset, task payload does not
    // ------------------------------------------------------------------
    logic [NUM_CPUS-1:0] slot_v_reg;
    task_t               slot_task_reg [NUM_CPUS];
    logic                cpu_ok;
    logic [SLOT_IDX_W-1:0] slot_idx;
    logic                slot_hit;
    logic                slot_set;
    logic                slot_clr;

    assign cpu_ok   = (32'(cpu_reg) < NUM_CPUS);
    assign slot_idx = SLOT_IDX_W'(cpu_reg);
    assign slot_hit = cpu_ok && slot_v_reg[slot_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_v_reg <= '0;
        end
        else if (slot_set)
        begin
            slot_v_reg[slot_idx] <= 1'b1;
        end
        else if (slot_clr)
        begin
            slot_v_reg[slot_idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_set)
        begin
            slot_task_reg[slot_idx] <= task_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stacks: chains of cells, top of stack in cell 0
    // ------------------------------------------------------------------
    stk_ctl_t rdy_ctl;
    stk_ctl_t unb_ctl;
    stk_ctl_t idl_ctl;
    task_t    rdy_push_val;
    task_t    idl_push_val;
    task_t    rdy_cell [READY_DEPTH];
    task_t    unb_cell [UNBLK_DEPTH];
    task_t    idl_cell [IDLE_DEPTH];

    logic [RDY_CNT_W-1:0] rdy_cnt_reg;
    logic [UNB_CNT_W-1:0] unb_cnt_reg;
    logic [IDL_CNT_W-1:0] idl_cnt_reg;

    logic rdy_full, rdy_empty;
    logic unb_full, unb_empty;
    logic idl_full, idl_empty;

    assign rdy_full  = (rdy_cnt_reg == RDY_CNT_W'(READY_DEPTH));
    assign unb_full  = (unb_cnt_reg == UNB_CNT_W'(UNBLK_DEPTH));
    assign idl_full  = (idl_cnt_reg == IDL_CNT_W'(IDLE_DEPTH));
    assign rdy_empty = (rdy_cnt_reg == '0);
    assign unb_empty = (unb_cnt_reg == '0);
    assign idl_empty = (idl_cnt_reg == '0);

    genvar gi;

    generate
        for (gi = 0; gi < READY_DEPTH; gi++)
        begin : g_rdy
            task_t up_w;
            task_t down_w;
            if (gi == 0)
            begin : g_top
                assign up_w = rdy_push_val;
            end
            else
            begin : g_mid
                assign up_w = rdy_cell[gi-1];
            end
            if (gi == READY_DEPTH - 1)
            begin : g_bot
                assign down_w = rdy_cell[gi];
            end
            else
            begin : g_nbot
                assign down_w = rdy_cell[gi+1];
            end
            isg_stack_cell u_cell (
                .clk       (clk),
                .ctl       (rdy_ctl),
                .up_data   (up_w),
                .down_data (down_w),
                .data      (rdy_cell[gi])
            );
        end

        for (gi = 0; gi < UNBLK_DEPTH; gi++)
        begin : g_unb
            task_t up_w;
            task_t down_w;
            if (gi == 0)
            begin : g_top
                assign up_w = task_reg;
            end
            else
            begin : g_mid
                assign up_w = unb_cell[gi-1];
            end
            if (gi == UNBLK_DEPTH - 1)
            begin : g_bot
                assign down_w = unb_cell[gi];
            end
            else
            begin : g_nbot
                assign down_w = unb_cell[gi+1];
            end
            isg_stack_cell u_cell (
                .clk       (clk),
                .ctl       (unb_ctl),
                .up_data   (up_w),
                .down_data (down_w),
                .data      (unb_cell[gi])
            );
        end

        for (gi = 0; gi < IDLE_DEPTH; gi++)
        begin : g_idl
            task_t up_w;
            task_t down_w;
            if (gi == 0)
            begin : g_top
                assign up_w = idl_push_val;
            end
            else
            begin : g_mid
                assign up_w = idl_cell[gi-1];
            end
            if (gi == IDLE_DEPTH - 1)
            begin : g_bot
                assign down_w = idl_cell[gi];
            end
            else
            begin : g_nbot
                assign down_w = idl_cell[gi+1];
            end
            isg_stack_cell u_cell (
                .clk       (clk),
                .ctl       (idl_ctl),
                .up_data   (up_w),
                .down_data (down_w),
                .data      (idl_cell[gi])
            );
        end
    endgenerate

    // idle CPU ids ride in task-wide cells, zero-extended
    assign idl_push_val = TASK_BITS'(cpu_reg);

    // ------------------------------------------------------------------
    // Execute: decode the operation against slot and stack tops
    // ------------------------------------------------------------------
    task_t               res_task;
    logic                res_tv;
    logic [CPU_ID_W-1:0] res_cpu;
    logic                res_cv;
    logic                res_ovf;
    logic                exec;

    assign exec = (state_reg == ST_EXEC);

    always_comb
    begin
        rdy_ctl      = '0;
        unb_ctl      = '0;
        idl_ctl      = '0;
        rdy_push_val = task_reg;
        slot_set     = 1'b0;
        slot_clr     = 1'b0;
        res_task     = '0;
        res_tv       = 1'b0;
        res_cpu      = '0;
        res_cv       = 1'b0;
        res_ovf      = 1'b0;
        if (exec)
        begin
            unique case (func_reg)
                FN_ADD_READY:
                begin
                    if (has_cpu_reg && cpu_ok && !child_reg && !slot_v_reg[slot_idx])
                    begin
                        slot_set = 1'b1;
                    end
                    else
                    begin
                        // push the task, wake an idle CPU if any
                        rdy_ctl.push = !rdy_full;
                        res_ovf      = rdy_full;
                        if (!idl_empty)
                        begin
                            idl_ctl.pop = 1'b1;
                            res_cpu     = idl_cell[0][CPU_ID_W-1:0];
                            res_cv      = 1'b1;
                        end
                    end
                end
                FN_UNBLOCK:
                begin
                    unb_ctl.push = !unb_full;
                    res_ovf      = unb_full;
                end
                FN_GET_READY:
                begin
                    // slot first, then unblocked, then ready, else go idle
                    if (slot_hit)
                    begin
                        slot_clr = 1'b1;
                        res_task = slot_task_reg[slot_idx];
                        res_tv   = 1'b1;
                    end
                    else if (!unb_empty)
                    begin
                        unb_ctl.pop = 1'b1;
                        res_task    = unb_cell[0];
                        res_tv      = 1'b1;
                    end
                    else if (!rdy_empty)
                    begin
                        rdy_ctl.pop = 1'b1;
                        res_task    = rdy_cell[0];
                        res_tv      = 1'b1;
                    end
                    else
                    begin
                        idl_ctl.push = !idl_full;
                        res_ovf      = idl_full;
                    end
                end
                FN_GET_IDLE:
                begin
                    if ((force_reg || !rdy_empty || !unb_empty) && !idl_empty)
                    begin
                        idl_ctl.pop = 1'b1;
                        res_cpu     = idl_cell[0][CPU_ID_W-1:0];
                        res_cv      = 1'b1;
                    end
                end
                FN_DISABLE:
                begin
                    // slot task is lost if the ready stack is full
                    if (slot_hit)
                    begin
                        slot_clr     = 1'b1;
                        rdy_push_val = slot_task_reg[slot_idx];
                        rdy_ctl.push = !rdy_full;
                        res_ovf      = rdy_full;
                    end
                end
                default:
                begin
                    res_ovf = 1'b0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stack fill counts
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdy_cnt_reg <= '0;
            unb_cnt_reg <= '0;
            idl_cnt_reg <= '0;
        end
        else
        begin
            if (rdy_ctl.push)
            begin
                rdy_cnt_reg <= rdy_cnt_reg + RDY_CNT_W'(1);
            end
            else if (rdy_ctl.pop)
            begin
                rdy_cnt_reg <= rdy_cnt_reg - RDY_CNT_W'(1);
            end
            if (unb_ctl.push)
            begin
                unb_cnt_reg <= unb_cnt_reg + UNB_CNT_W'(1);
            end
            else if (unb_ctl.pop)
            begin
                unb_cnt_reg <= unb_cnt_reg - UNB_CNT_W'(1);
            end
            if (idl_ctl.push)
            begin
                idl_cnt_reg <= idl_cnt_reg + IDL_CNT_W'(1);
            end
            else if (idl_ctl.pop)
            begin
                idl_cnt_reg <= idl_cnt_reg - IDL_CNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register, shown for one cycle with done
    // ------------------------------------------------------------------
    logic                  done_reg;
    logic [TASK_ID_W-1:0]  out_task_reg;
    logic                  task_valid_reg;
    logic [CPU_ID_W-1:0]   out_cpu_reg;
    logic                  cpu_valid_reg;
    logic                  overflow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            out_task_reg   <= TASK_ID_W'(res_task);
            task_valid_reg <= res_tv;
            out_cpu_reg    <= res_cpu;
            cpu_valid_reg  <= res_cv;
            overflow_reg   <= res_ovf;
        end
    end

    assign done       = done_reg;
    assign out_task   = out_task_reg;
    assign task_valid = task_valid_reg;
    assign out_cpu    = out_cpu_reg;
    assign cpu_valid  = cpu_valid_reg;
    assign overflow   = overflow_reg;

`ifndef SYNTHESIS
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_EXEC))
        else $error("result word without an execute cycle");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(task_valid && cpu_valid))
        else $error("result carries both a task and a cpu");

    a_rdy_shift: assert property (@(posedge clk) disable iff (!rst_n)
        !(rdy_ctl.push && rdy_ctl.pop) && !(rdy_ctl.push && rdy_full)
        && !(rdy_ctl.pop && rdy_empty))
        else $error("illegal ready stack shift");

    a_idl_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> $stable(idl_cnt_reg))
        else $error("idle count moved outside execute");
`endif

endmodule
